/* sv/emgenv_pkg.sv */
package emgenv_pkg;

    localparam int MAG_W      = 12;
    localparam int MAG_MAX    = 2048;
    localparam int ENV_W      = 12;
    localparam int THR_W      = 12;
    localparam int ANG_W      = 8;
    localparam int PULSE_W    = 10;
    localparam int PULSE_BASE = 150;

    localparam logic [2:0] REG_THRESHOLD    = 3'd0;
    localparam logic [2:0] REG_SWEEP_MIN    = 3'd1;
    localparam logic [2:0] REG_SWEEP_MAX    = 3'd2;
    localparam logic [2:0] REG_LIFT_MIN     = 3'd3;
    localparam logic [2:0] REG_LIFT_MAX     = 3'd4;
    localparam logic [2:0] REG_GRIP_CLOSE   = 3'd5;
    localparam logic [2:0] REG_GRIP_RELEASE = 3'd6;
    localparam logic [2:0] REG_TURN_ANGLE   = 3'd7;

    typedef struct packed {
        logic [THR_W-1:0] threshold;
        logic [ANG_W-1:0] sweep_min;
        logic [ANG_W-1:0] sweep_max;
        logic [ANG_W-1:0] lift_min;
        logic [ANG_W-1:0] lift_max;
        logic [ANG_W-1:0] grip_close;
        logic [ANG_W-1:0] grip_release;
        logic [ANG_W-1:0] turn_angle;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        threshold:    12'd3,
        sweep_min:    8'd40,
        sweep_max:    8'd90,
        lift_min:     8'd20,
        lift_max:     8'd60,
        grip_close:   8'd80,
        grip_release: 8'd140,
        turn_angle:   8'd65
    };

    typedef struct packed {
        logic [ENV_W-1:0]   envelope;
        logic               is_active;
        logic [ANG_W-1:0]   sweep_out;
        logic [PULSE_W-1:0] sweep_pulse;
        logic [ANG_W-1:0]   lift_out;
        logic [PULSE_W-1:0] lift_pulse;
        logic [ANG_W-1:0]   grip_out;
        logic [PULSE_W-1:0] grip_pulse;
        logic               grip_moved;
    } result_t;

    // 150 + angle*450/180 == 150 + floor(angle*5/2)
    function automatic logic [PULSE_W-1:0] pulse_of(input logic [ANG_W-1:0] angle);
        logic [10:0] x5;
        x5 = ({3'b000, angle} << 2) + {3'b000, angle};
        return x5[10:1] + PULSE_W'(PULSE_BASE);
    endfunction

endpackage

/* sv/emgenv_cell.sv */
module emgenv_cell
    import emgenv_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             shift_en,
    input  logic [MAG_W-1:0] mag_in,
    output logic [MAG_W-1:0] mag_out
);

    logic [MAG_W-1:0] mag_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mag_reg <= '0;
        end else if (shift_en) begin
            mag_reg <= mag_in;
        end
    end

    assign mag_out = mag_reg;

endmodule

/* sv/emgenv_arm.sv */
module emgenv_arm
    import emgenv_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             step,
    input  cfg_t             cfg,
    input  logic [ENV_W-1:0] envelope,
    output result_t          res
);

    typedef logic signed [9:0] sang_t;

    logic [ANG_W-1:0] sweep_reg, sweep_next;
    logic [ANG_W-1:0] lift_reg, lift_next;
    logic [ANG_W-1:0] grip_reg, grip_next;

    sang_t sa, la, smin, smax, lmin, lmax, glo, ghi, turn;
    sang_t up, down, snx, lnx, gcmd;
    logic  active, moved;

    function automatic sang_t ext(input logic [ANG_W-1:0] a);
        return $signed({2'b00, a});
    endfunction

    function automatic sang_t clamp_to(input sang_t x, input sang_t lo, input sang_t hi);
        if (x < lo) return lo;
        if (x > hi) return hi;
        return x;
    endfunction

    always_comb begin
        sa   = ext(sweep_reg);
        la   = ext(lift_reg);
        smin = ext(cfg.sweep_min);
        smax = ext(cfg.sweep_max);
        lmin = ext(cfg.lift_min);
        lmax = ext(cfg.lift_max);
        glo  = ext(cfg.grip_close);
        ghi  = ext(cfg.grip_release);
        turn = ext(cfg.turn_angle);

        active = envelope > cfg.threshold;
        up     = (la + 10'sd2 < lmax) ? la + 10'sd2 : lmax;
        down   = (la - 10'sd2 > lmin) ? la - 10'sd2 : lmin;

        if (active) begin
            moved = (sa == smax - 10'sd1);
            gcmd  = clamp_to(glo, glo, ghi);
            snx   = (sa + 10'sd1 < smax) ? sa + 10'sd1 : smax;
            lnx   = (sa < turn) ? up : down;
        end else begin
            moved = (sa == smin + 10'sd1);
            gcmd  = clamp_to(ghi, glo, ghi);
            snx   = (sa - 10'sd1 > smin) ? sa - 10'sd1 : smin;
            lnx   = (sa < turn) ? down : up;
        end

        sweep_next = ANG_W'(clamp_to(snx, smin, smax));
        lift_next  = ANG_W'(clamp_to(lnx, lmin, lmax));
        grip_next  = moved ? ANG_W'(gcmd) : grip_reg;

        res.envelope    = envelope;
        res.is_active   = active;
        res.sweep_out   = sweep_next;
        res.sweep_pulse = pulse_of(sweep_next);
        res.lift_out    = lift_next;
        res.lift_pulse  = pulse_of(lift_next);
        res.grip_out    = grip_next;
        res.grip_pulse  = pulse_of(grip_next);
        res.grip_moved  = moved;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sweep_reg <= CFG_RESET.sweep_min;
            lift_reg  <= CFG_RESET.lift_min;
            grip_reg  <= CFG_RESET.grip_release;
        end else if (step) begin
            sweep_reg <= sweep_next;
            lift_reg  <= lift_next;
            grip_reg  <= grip_next;
        end
    end

endmodule

/* sv/emg_envelope_sweep_drive.sv */
// EMG envelope follower driving a sweep / lift / gripper arm. Each input transfer carries one
// filtered sample; its magnitude enters a shift line of WINDOW cells (cleared by reset) and a
// running sum tracks the window. The envelope (sum / WINDOW, by reciprocal multiply) decides
// whether the sweep joint steps up or down, the lift joint follows by 2 with its direction
// reversing at turn_angle, and the gripper closes or opens near the sweep limits. One result
// transfer per input transfer, registered through sum_reg, prod_reg and out_reg; one transfer
// per cycle is sustained while the output is not stalled by m_tready. Configuration
// writes are meant for idle periods only.
module emg_envelope_sweep_drive
    import emgenv_pkg::*;
#(
    parameter int WINDOW = 100
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,     // [11:0] filtered_sample
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,     // [11:0] envelope, [12] is_active, [20:13] sweep_out,
                                     // [30:21] sweep_pulse, [38:31] lift_out,
                                     // [48:39] lift_pulse, [56:49] grip_out,
                                     // [66:57] grip_pulse, [67] grip_moved
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [11:0] cfg_wdata
);

    localparam int SUM_W     = $clog2(MAG_MAX * WINDOW + 1);
    localparam int DIV_SHIFT = SUM_W + $clog2(WINDOW);
    localparam int RECIP_W   = SUM_W + 2;
    localparam int PROD_W    = SUM_W + RECIP_W;
    localparam logic [63:0] RECIP =
        ((64'd1 << DIV_SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);

    cfg_t cfg_reg;

    logic signed [MAG_W-1:0] sample;
    logic [MAG_W-1:0]        mag;
    logic [MAG_W-1:0]        tap [WINDOW];
    logic [SUM_W-1:0]        sum_reg, sum_next;
    logic [PROD_W-1:0]       prod_reg, prod_next;
    logic                    v1_reg, v2_reg, out_valid_reg;
    logic                    accept, adv2, adv_out;
    logic [ENV_W-1:0]        envelope;
    result_t                 res, out_reg;

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= CFG_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_THRESHOLD:    cfg_reg.threshold    <= cfg_wdata;
                REG_SWEEP_MIN:    cfg_reg.sweep_min    <= cfg_wdata[ANG_W-1:0];
                REG_SWEEP_MAX:    cfg_reg.sweep_max    <= cfg_wdata[ANG_W-1:0];
                REG_LIFT_MIN:     cfg_reg.lift_min     <= cfg_wdata[ANG_W-1:0];
                REG_LIFT_MAX:     cfg_reg.lift_max     <= cfg_wdata[ANG_W-1:0];
                REG_GRIP_CLOSE:   cfg_reg.grip_close   <= cfg_wdata[ANG_W-1:0];
                REG_GRIP_RELEASE: cfg_reg.grip_release <= cfg_wdata[ANG_W-1:0];
                REG_TURN_ANGLE:   cfg_reg.turn_angle   <= cfg_wdata[ANG_W-1:0];
                default: ;
            endcase
        end
    end

    // pipeline control
    assign adv_out  = v2_reg & (~out_valid_reg | m_tready);
    assign adv2     = v1_reg & (~v2_reg | adv_out);
    assign s_tready = ~v1_reg | adv2;
    assign accept   = s_tvalid & s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            v1_reg        <= accept | (v1_reg & ~adv2);
            v2_reg        <= adv2 | (v2_reg & ~adv_out);
            out_valid_reg <= adv_out | (out_valid_reg & ~m_tready);
        end
    end

    // window shift line
    assign sample = s_tdata[MAG_W-1:0];
    assign mag    = sample[MAG_W-1] ? (~sample[MAG_W-1:0] + MAG_W'(1)) : sample[MAG_W-1:0];

    for (genvar i = 0; i < WINDOW; i++) begin : g_cell
        emgenv_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .shift_en (accept),
            .mag_in   ((i == 0) ? mag : tap[(i == 0) ? 0 : i - 1]),
            .mag_out  (tap[i])
        );
    end

    assign sum_next = sum_reg - SUM_W'(tap[WINDOW-1]) + SUM_W'(mag);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg <= '0;
        end else if (accept) begin
            sum_reg <= sum_next;
        end
    end

    // envelope = sum / WINDOW, exact for every sum below 2**SUM_W
    assign prod_next = {{RECIP_W{1'b0}}, sum_reg} * {{SUM_W{1'b0}}, RECIP_W'(RECIP)};

    always_ff @(posedge aclk) begin
        if (adv2) begin
            prod_reg <= prod_next;
        end
    end

    assign envelope = prod_reg[DIV_SHIFT +: ENV_W];

    emgenv_arm u_arm (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .step     (adv_out),
        .cfg      (cfg_reg),
        .envelope (envelope),
        .res      (res)
    );

    always_ff @(posedge aclk) begin
        if (adv_out) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, out_reg.grip_moved, out_reg.grip_pulse, out_reg.grip_out,
                       out_reg.lift_pulse, out_reg.lift_out, out_reg.sweep_pulse,
                       out_reg.sweep_out, out_reg.is_active, out_reg.envelope};

    a_env_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> out_reg.envelope <= ENV_W'(MAG_MAX))
        else $error("envelope above full-scale magnitude");

    a_grip_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && out_reg.grip_moved) |->
            (out_reg.grip_out == cfg_reg.grip_close ||
             out_reg.grip_out == cfg_reg.grip_release))
        else $error("gripper command not at a gripper limit");

    a_pulse: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (out_reg.sweep_pulse == pulse_of(out_reg.sweep_out) &&
                      out_reg.lift_pulse == pulse_of(out_reg.lift_out)))
        else $error("pulse does not match angle");

    a_active: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (out_reg.is_active == (out_reg.envelope > cfg_reg.threshold)))
        else $error("active flag disagrees with envelope");

endmodule

/* test/emg_envelope_sweep_drive_tb.sv */
module emg_envelope_sweep_drive_tb;
    import emgenv_pkg::*;

    localparam int WIN         = 100;
    localparam int SERVO_SPAN  = 450;
    localparam int ANGLE_RANGE = 180;
    localparam int SETTLE_CYC  = 6;

    typedef enum int {FLOW, SPARSE, PERIODIC, CHOKED} stall_mode_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [71:0] m_tdata;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [11:0] cfg_wdata;

    emg_envelope_sweep_drive #(.WINDOW(WIN)) i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // arm model state
    cfg_t        arm_cfg;
    int unsigned mag_ring[WIN];
    int unsigned mag_sum;
    int          ring_pos;
    int          sweep_deg;
    int          lift_deg;
    int          grip_deg;

    result_t     pending_results[$];
    int          mismatches;
    int          burst_left;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic int clamp_deg(input int x, input int lo, input int hi);
        if (x < lo) return lo;
        if (x > hi) return hi;
        return x;
    endfunction

    function automatic logic [PULSE_W-1:0] servo_pulse(input int angle);
        return PULSE_W'(PULSE_BASE + (angle * SERVO_SPAN) / ANGLE_RANGE);
    endfunction

    task automatic predict_arm_step(input logic [11:0] raw);
        int unsigned mag;
        int unsigned env;
        bit          act;
        bit          moved;
        int          s_min, s_max, l_min, l_max, g_lo, g_hi, turn;
        int          s_nxt, l_nxt;
        result_t     r;
        s_min = arm_cfg.sweep_min;
        s_max = arm_cfg.sweep_max;
        l_min = arm_cfg.lift_min;
        l_max = arm_cfg.lift_max;
        g_lo  = arm_cfg.grip_close;
        g_hi  = arm_cfg.grip_release;
        turn  = arm_cfg.turn_angle;
        moved = 1'b0;
        mag = raw[11] ? (4096 - raw) : raw;
        mag_sum = mag_sum - mag_ring[ring_pos] + mag;
        mag_ring[ring_pos] = mag;
        ring_pos = (ring_pos + 1) % WIN;
        env = mag_sum / WIN;
        act = env > arm_cfg.threshold;
        // decisions use the sweep angle from before this step
        if (act) begin
            if (sweep_deg == s_max - 1) begin
                grip_deg = clamp_deg(g_lo, g_lo, g_hi);
                moved = 1'b1;
            end
            s_nxt = (sweep_deg + 1 < s_max) ? sweep_deg + 1 : s_max;
            if (sweep_deg < turn)
                l_nxt = (lift_deg + 2 < l_max) ? lift_deg + 2 : l_max;
            else
                l_nxt = (lift_deg - 2 > l_min) ? lift_deg - 2 : l_min;
        end else begin
            if (sweep_deg == s_min + 1) begin
                grip_deg = clamp_deg(g_hi, g_lo, g_hi);
                moved = 1'b1;
            end
            s_nxt = (sweep_deg - 1 > s_min) ? sweep_deg - 1 : s_min;
            if (sweep_deg < turn)
                l_nxt = (lift_deg - 2 > l_min) ? lift_deg - 2 : l_min;
            else
                l_nxt = (lift_deg + 2 < l_max) ? lift_deg + 2 : l_max;
        end
        sweep_deg = clamp_deg(s_nxt, s_min, s_max);
        lift_deg  = clamp_deg(l_nxt, l_min, l_max);
        r.envelope    = ENV_W'(env);
        r.is_active   = act;
        r.sweep_out   = ANG_W'(sweep_deg);
        r.sweep_pulse = servo_pulse(sweep_deg);
        r.lift_out    = ANG_W'(lift_deg);
        r.lift_pulse  = servo_pulse(lift_deg);
        r.grip_out    = ANG_W'(grip_deg);
        r.grip_pulse  = servo_pulse(grip_deg);
        r.grip_moved  = moved;
        pending_results.push_back(r);
    endtask

    task automatic send_sample(input logic [11:0] smp);
        int gap;
        @(negedge aclk);
        if (burst_left == 0) begin
            if ($urandom_range(0, 4) == 0) begin
                burst_left = $urandom_range(40, 150);
                gap = 0;
            end else begin
                burst_left = $urandom_range(1, 20);
                gap = $urandom_range(0, 6);
            end
            if (gap > 0) begin
                s_tvalid = 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
        burst_left--;
        s_tvalid = 1'b1;
        s_tdata  = {4'h0, smp};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_arm_step(smp);
    endtask

    task automatic settle_arm();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYC) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [11:0] val);
        @(negedge aclk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_wdata = val;
        case (idx)
            REG_THRESHOLD:    arm_cfg.threshold    = val;
            REG_SWEEP_MIN:    arm_cfg.sweep_min    = val[7:0];
            REG_SWEEP_MAX:    arm_cfg.sweep_max    = val[7:0];
            REG_LIFT_MIN:     arm_cfg.lift_min     = val[7:0];
            REG_LIFT_MAX:     arm_cfg.lift_max     = val[7:0];
            REG_GRIP_CLOSE:   arm_cfg.grip_close   = val[7:0];
            REG_GRIP_RELEASE: arm_cfg.grip_release = val[7:0];
            REG_TURN_ANGLE:   arm_cfg.turn_angle   = val[7:0];
            default: ;
        endcase
    endtask

    // angles keep their values across writes; only the configuration registers change
    task automatic apply_settings(input logic [11:0] thr, smin, smax, lmin, lmax,
                                  gclose, grel, turn);
        settle_arm();
        write_reg(REG_THRESHOLD, thr);
        write_reg(REG_SWEEP_MIN, smin);
        write_reg(REG_SWEEP_MAX, smax);
        write_reg(REG_LIFT_MIN, lmin);
        write_reg(REG_LIFT_MAX, lmax);
        write_reg(REG_GRIP_CLOSE, gclose);
        write_reg(REG_GRIP_RELEASE, grel);
        write_reg(REG_TURN_ANGLE, turn);
        @(negedge aclk);
        cfg_we = 1'b0;
    endtask

    // randomly chosen high or low activity segments, with some full-range noise
    task automatic run_swings(input int thr, input int count);
        int          left, seg, level, mag;
        logic [11:0] raw;
        left = count;
        while (left > 0) begin
            seg = $urandom_range(30, 150);
            if (seg > left) seg = left;
            if ($urandom_range(0, 1)) level = thr + $urandom_range(30, 400);
            else level = thr / 3;
            if (level > 2040) level = 2040;
            repeat (seg) begin
                if ($urandom_range(0, 11) == 0) begin
                    raw = $urandom_range(0, 4095);
                end else begin
                    mag = $urandom_range(0, 2 * level);
                    if (mag > MAG_MAX) mag = MAG_MAX;
                    raw = $urandom_range(0, 1) ? 12'(-mag) : 12'(mag);
                end
                send_sample(raw);
            end
            left -= seg;
        end
    endtask

    task automatic compare_field(input string name, input int unsigned want,
                                 input int unsigned got);
        if (want != got) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch in %s: expected %0d, got %0d", name, want, got);
        end
    endtask

    task automatic check_result(input logic [71:0] d);
        result_t got, want;
        got.envelope    = d[11:0];
        got.is_active   = d[12];
        got.sweep_out   = d[20:13];
        got.sweep_pulse = d[30:21];
        got.lift_out    = d[38:31];
        got.lift_pulse  = d[48:39];
        got.grip_out    = d[56:49];
        got.grip_pulse  = d[66:57];
        got.grip_moved  = d[67];
        if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("result transfer with nothing pending: %h", d);
        end else begin
            want = pending_results.pop_front();
            compare_field("envelope", want.envelope, got.envelope);
            compare_field("is_active", want.is_active, got.is_active);
            compare_field("sweep_out", want.sweep_out, got.sweep_out);
            compare_field("sweep_pulse", want.sweep_pulse, got.sweep_pulse);
            compare_field("lift_out", want.lift_out, got.lift_out);
            compare_field("lift_pulse", want.lift_pulse, got.lift_pulse);
            compare_field("grip_out", want.grip_out, got.grip_out);
            compare_field("grip_pulse", want.grip_pulse, got.grip_pulse);
            compare_field("grip_moved", want.grip_moved, got.grip_moved);
        end
    endtask

    initial begin
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid === 1'b1 && m_tready) check_result(m_tdata);
        end
    end

    initial begin
        stall_mode_t mode;
        int          span;
        int          n;
        m_tready = 1'b0;
        forever begin
            mode = stall_mode_t'($urandom_range(0, 3));
            span = $urandom_range(20, 200);
            for (n = 0; n < span; n++) begin
                @(negedge aclk);
                case (mode)
                    FLOW:     m_tready = 1'b1;
                    SPARSE:   m_tready = ($urandom_range(0, 3) != 0);
                    PERIODIC: m_tready = (n % 5 >= 2);
                    default:  m_tready = ($urandom_range(0, 7) == 0);
                endcase
            end
        end
    end

    task automatic test_sample_extremes();
        send_sample(12'h000);
        send_sample(12'h7FF);
        send_sample(12'h800);
        send_sample(12'hFFF);
        send_sample(12'h001);
        send_sample(12'h555);
        send_sample(12'hAAA);
        repeat (6) begin
            send_sample(12'h7FF);
            send_sample(12'h800);
        end
        send_sample(12'h000);
    endtask

    // narrow sweep range so the gripper closes and opens repeatedly
    task automatic test_grip_cycle();
        apply_settings(12'd200, 12'd30, 12'd36, 12'd10, 12'd20, 12'd60, 12'd120, 12'd33);
        run_swings(200, 200);
    endtask

    task automatic test_crossed_limits();
        apply_settings(12'd150, 12'd70, 12'd64, 12'd100, 12'd90, 12'd170, 12'd20, 12'd67);
        run_swings(150, 120);
    endtask

    task automatic test_zero_limits();
        apply_settings(12'd0, 12'd0, 12'd0, 12'd0, 12'd5, 12'd0, 12'd180, 12'd0);
        run_swings(0, 80);
        apply_settings(12'd300, 12'd0, 12'd4, 12'd0, 12'd180, 12'd10, 12'd170, 12'd2);
        run_swings(300, 120);
    endtask

    // 8-bit registers first get all-ones write data, upper bits dropped, then full 8-bit ranges
    task automatic test_register_extremes();
        apply_settings(12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF,
                       12'hFFF);
        run_swings(2048, 60);
        apply_settings(12'd0, 12'd0, 12'd255, 12'd250, 12'd255, 12'd0, 12'd255, 12'd128);
        run_swings(0, 80);
    endtask

    task automatic test_random_settings();
        logic [11:0] thr, smin, smax, lmin, lmax, gclose, grel, turn;
        repeat (4) begin
            thr    = $urandom_range(0, 1500);
            smin   = $urandom_range(0, 170);
            smax   = smin + $urandom_range(2, 10);
            turn   = $urandom_range(smin, smax);
            lmin   = $urandom_range(0, 150);
            lmax   = lmin + $urandom_range(0, 30);
            gclose = $urandom_range(0, 180);
            grel   = $urandom_range(0, 180);
            if ($urandom_range(0, 3) == 0) begin
                smin   = $urandom_range(0, 4095);
                smax   = $urandom_range(0, 4095);
                lmin   = $urandom_range(0, 4095);
                lmax   = $urandom_range(0, 4095);
                gclose = $urandom_range(0, 4095);
                grel   = $urandom_range(0, 4095);
                turn   = $urandom_range(0, 4095);
            end
            apply_settings(thr, smin, smax, lmin, lmax, gclose, grel, turn);
            run_swings(thr, $urandom_range(90, 130));
        end
    endtask

    initial begin
        aresetn    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        cfg_we     = 1'b0;
        cfg_index  = '0;
        cfg_wdata  = '0;
        mismatches = 0;
        burst_left = 0;
        arm_cfg    = CFG_RESET;
        foreach (mag_ring[i]) mag_ring[i] = 0;
        mag_sum    = 0;
        ring_pos   = 0;
        sweep_deg  = CFG_RESET.sweep_min;
        lift_deg   = CFG_RESET.lift_min;
        grip_deg   = CFG_RESET.grip_release;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_sample_extremes();
        test_grip_cycle();
        test_crossed_limits();
        test_zero_limits();
        test_register_extremes();
        test_random_settings();

        settle_arm();
        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

/* sim.f */
sv/emgenv_pkg.sv
sv/emgenv_cell.sv
sv/emgenv_arm.sv
sv/emg_envelope_sweep_drive.sv
test/emg_envelope_sweep_drive_tb.sv
